// ===== hw/rtl/mpwa_pkg.sv =====
// Shared types and constants for the max-pool window argmax block.
// Depends on nothing; used by the top level, the frame store and the checker.
`default_nettype none

package mpwa_pkg;

  // Fixed field widths of the request and result words
  localparam int VALUE_BITS = 16;
  localparam int CH_BITS    = 2;
  localparam int POS_BITS   = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 6;

  // Width of internal coordinate math: output position times stride plus window reach
  localparam int COORD_BITS = 10;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_CHANNEL_COUNT = 3'd2,
    CFG_WINDOW_SIZE   = 3'd3,
    CFG_WINDOW_STRIDE = 3'd4
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== hw/rtl/mpwa_store.sv =====
// Frame store: one write port and one registered read port.
// Depends on mpwa_pkg for the pixel width.
`default_nettype none

module mpwa_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [AW-1:0]                        waddr_i,
  input  wire logic signed [mpwa_pkg::VALUE_BITS-1:0] wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [AW-1:0]                        raddr_i,
  output logic signed [mpwa_pkg::VALUE_BITS-1:0]    rdata_o
);

  logic signed [mpwa_pkg::VALUE_BITS-1:0] mem [DEPTH];

  // Store one pixel word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Fetch one pixel word, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/max_pool_window_argmax.sv =====
// Max pooling with argmax over one stored image; a write stores a pixel and a query
// scans the clipped window one pixel per cycle through the single store read port.
// A write or a rejected request gives its result in the cycle after it is accepted.
// A query over N clipped window pixels (N <= 64) keeps busy high through the scan and
// strobes done_o as busy falls. The receiver cannot stall; results are one-cycle words.
// Reset (rst_ni low, async) clears control and loads register defaults; store contents
// are undefined until written.
`default_nettype none

module max_pool_window_argmax #(
  parameter int MAX_WIDTH    = 32,
  parameter int MAX_HEIGHT   = 32,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_WINDOW   = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // request channel
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    req_type_i,
  input  wire logic [mpwa_pkg::CH_BITS-1:0]            channel_sel_i,
  input  wire logic [mpwa_pkg::POS_BITS-1:0]           pos_row_i,
  input  wire logic [mpwa_pkg::POS_BITS-1:0]           pos_col_i,
  input  wire logic signed [mpwa_pkg::VALUE_BITS-1:0]  pixel_value_i,
  // configuration channel
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [mpwa_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [mpwa_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  // result channel
  output logic                                         done_o,
  output logic signed [mpwa_pkg::VALUE_BITS-1:0]       max_value_o,
  output logic [mpwa_pkg::POS_BITS-1:0]                max_row_o,
  output logic [mpwa_pkg::POS_BITS-1:0]                max_col_o,
  output logic                                         status_o
);

  localparam int CW     = mpwa_pkg::COORD_BITS;
  localparam int VB     = mpwa_pkg::VALUE_BITS;
  localparam int PB     = mpwa_pkg::POS_BITS;
  localparam int DEPTH  = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST
  } state_e;

  // Flat store address of channel, row, column
  function automatic logic [AW-1:0] addr_of(input logic [mpwa_pkg::CH_BITS-1:0] ch,
                                            input logic [CW-1:0] row,
                                            input logic [CW-1:0] col);
    logic [31:0] lin;
    lin = (32'(ch) * 32'(MAX_HEIGHT) + 32'(row)) * 32'(MAX_WIDTH) + 32'(col);
    return lin[AW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers, always ready
  logic [5:0] frame_width_q, frame_height_q;
  logic [2:0] channel_count_q;
  logic [3:0] window_size_q, window_stride_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= 6'd32;
      frame_height_q  <= 6'd32;
      channel_count_q <= 3'd1;
      window_size_q   <= 4'd2;
      window_stride_q <= 4'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mpwa_pkg::CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[5:0];
        mpwa_pkg::CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[5:0];
        mpwa_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[2:0];
        mpwa_pkg::CFG_WINDOW_SIZE:   window_size_q   <= cfg_data_i[3:0];
        mpwa_pkg::CFG_WINDOW_STRIDE: window_stride_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Effective geometry: saturate to limits, treat zero size or stride as one
  logic [CW-1:0] w_eff, h_eff, nch_eff, size_eff, stride_eff;
  logic [CW-1:0] fw_ext, fh_ext, nc_ext, ws_ext, wt_ext;

  always_comb begin
    fw_ext = CW'(frame_width_q);
    fh_ext = CW'(frame_height_q);
    nc_ext = CW'(channel_count_q);
    ws_ext = CW'(window_size_q);
    wt_ext = CW'(window_stride_q);
    w_eff   = (fw_ext > CW'(MAX_WIDTH))    ? CW'(MAX_WIDTH)    : fw_ext;
    h_eff   = (fh_ext > CW'(MAX_HEIGHT))   ? CW'(MAX_HEIGHT)   : fh_ext;
    nch_eff = (nc_ext > CW'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : nc_ext;
    size_eff = (ws_ext > CW'(MAX_WINDOW)) ? CW'(MAX_WINDOW) : ws_ext;
    if (size_eff == '0) size_eff = CW'(1);
    stride_eff = (wt_ext == '0) ? CW'(1) : wt_ext;
  end

  // ---------------------------------------------------------------------------
  // Request decode and window bounds at accept
  logic          accept;
  logic          ch_ok, wr_ok, qry_ok;
  logic [CW-1:0] row_in, col_in, anc_r, anc_c;
  logic [CW-1:0] half, lo_off, hi_off, r0, c0, r1, c1, r1_raw, c1_raw;

  always_comb begin
    row_in = CW'(pos_row_i);
    col_in = CW'(pos_col_i);
    ch_ok  = CW'(channel_sel_i) < nch_eff;
    wr_ok  = ch_ok && (row_in < h_eff) && (col_in < w_eff);
    anc_r  = row_in * stride_eff;
    anc_c  = col_in * stride_eff;
    // output position in range exactly when its anchor lies inside the image
    qry_ok = ch_ok && (anc_r < h_eff) && (anc_c < w_eff);
    half   = (size_eff - CW'(1)) >> 1;
    lo_off = size_eff[0] ? half : '0;
    hi_off = size_eff[0] ? half : (size_eff - CW'(1));
    r0     = (anc_r >= lo_off) ? (anc_r - lo_off) : '0;
    c0     = (anc_c >= lo_off) ? (anc_c - lo_off) : '0;
    r1_raw = anc_r + hi_off;
    c1_raw = anc_c + hi_off;
    r1     = (r1_raw > h_eff - CW'(1)) ? (h_eff - CW'(1)) : r1_raw;
    c1     = (c1_raw > w_eff - CW'(1)) ? (w_eff - CW'(1)) : c1_raw;
  end

  // ---------------------------------------------------------------------------
  // Sequencer and shared compare unit
  state_e                      state_q, state_d;
  logic [mpwa_pkg::CH_BITS-1:0] ch_q, ch_d;
  logic [CW-1:0]               row_q, row_d, col_q, col_d;
  logic [CW-1:0]               c0_q, c0_d, r1_q, r1_d, c1_q, c1_d;
  logic                        pend_q, pend_d;
  logic [CW-1:0]               prow_q, prow_d, pcol_q, pcol_d;
  logic                        have_q, have_d;
  logic signed [VB-1:0]        best_q, best_d;
  logic [CW-1:0]               brow_q, brow_d, bcol_q, bcol_d;
  logic                        done_q, done_d;
  logic signed [VB-1:0]        maxv_q, maxv_d;
  logic [PB-1:0]               mrow_q, mrow_d, mcol_q, mcol_d;
  logic                        stat_q, stat_d;

  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic signed [VB-1:0]        rdata;
  logic                        take;
  logic signed [VB-1:0]        cmp_best;
  logic [CW-1:0]               cmp_row, cmp_col;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Compare the word fetched last cycle against the running maximum
  always_comb begin
    take     = pend_q && (!have_q || (rdata > best_q));
    cmp_best = take ? rdata  : best_q;
    cmp_row  = take ? prow_q : brow_q;
    cmp_col  = take ? pcol_q : bcol_q;
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    row_d   = row_q;
    col_d   = col_q;
    c0_d    = c0_q;
    r1_d    = r1_q;
    c1_d    = c1_q;
    pend_d  = 1'b0;
    prow_d  = row_q;
    pcol_d  = col_q;
    have_d  = have_q || pend_q;
    best_d  = cmp_best;
    brow_d  = cmp_row;
    bcol_d  = cmp_col;
    done_d  = 1'b0;
    maxv_d  = maxv_q;
    mrow_d  = mrow_q;
    mcol_d  = mcol_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = addr_of(channel_sel_i, row_in, col_in);
    re      = 1'b0;
    raddr   = addr_of(ch_q, row_q, col_q);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == mpwa_pkg::REQ_WRITE) begin
            // store the pixel and report at once
            we     = wr_ok;
            done_d = 1'b1;
            maxv_d = '0;
            mrow_d = '0;
            mcol_d = '0;
            stat_d = wr_ok ? mpwa_pkg::STATUS_OK : mpwa_pkg::STATUS_ERR;
          end else if (!qry_ok) begin
            done_d = 1'b1;
            maxv_d = '0;
            mrow_d = '0;
            mcol_d = '0;
            stat_d = mpwa_pkg::STATUS_ERR;
          end else begin
            // load the clipped window and start the scan
            state_d = ST_SCAN;
            ch_d    = channel_sel_i;
            row_d   = r0;
            col_d   = c0;
            c0_d    = c0;
            r1_d    = r1;
            c1_d    = c1;
            have_d  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // fetch one window pixel and advance in row-major order
        re     = 1'b1;
        pend_d = 1'b1;
        if (col_q == c1_q) begin
          col_d = c0_q;
          if (row_q == r1_q) begin
            state_d = ST_LAST;
          end else begin
            row_d = row_q + CW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      ST_LAST: begin
        // fold in the final pixel and report
        state_d = ST_IDLE;
        done_d  = 1'b1;
        maxv_d  = cmp_best;
        mrow_d  = cmp_row[PB-1:0];
        mcol_d  = cmp_col[PB-1:0];
        stat_d  = mpwa_pkg::STATUS_OK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      have_q  <= have_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    row_q  <= row_d;
    col_q  <= col_d;
    c0_q   <= c0_d;
    r1_q   <= r1_d;
    c1_q   <= c1_d;
    prow_q <= prow_d;
    pcol_q <= pcol_d;
    best_q <= best_d;
    brow_q <= brow_d;
    bcol_q <= bcol_d;
    maxv_q <= maxv_d;
    mrow_q <= mrow_d;
    mcol_q <= mcol_d;
    stat_q <= stat_d;
  end

  mpwa_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (pixel_value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign done_o      = done_q;
  assign max_value_o = maxv_q;
  assign max_row_o   = mrow_q;
  assign max_col_o   = mcol_q;
  assign status_o    = stat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mpwa_checker.sv =====
// Port-level checks for max_pool_window_argmax, bound to the top level.
// Depends on mpwa_pkg for request and status codes.
`default_nettype none

module mpwa_checker (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   start,
  input wire logic                                   busy,
  input wire logic                                   req_type_i,
  input wire logic                                   done_o,
  input wire logic signed [mpwa_pkg::VALUE_BITS-1:0] max_value_o,
  input wire logic [mpwa_pkg::POS_BITS-1:0]          max_row_o,
  input wire logic [mpwa_pkg::POS_BITS-1:0]          max_col_o,
  input wire logic                                   status_o
);

  // No result word while a scan is running
  a_no_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o)
    else $error("result word during scan");

  // An error word carries zero payload
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == mpwa_pkg::STATUS_ERR) |->
      (max_value_o == '0 && max_row_o == '0 && max_col_o == '0))
    else $error("error word with nonzero payload");

  // A write answers in the next cycle without going busy
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == mpwa_pkg::REQ_WRITE) |=> (done_o && !busy))
    else $error("write not answered next cycle");

  // Every accepted word either answers at once or starts a scan
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted word dropped");

  // A finished scan always delivers a good result
  a_scan_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (done_o && status_o == mpwa_pkg::STATUS_OK))
    else $error("scan ended without result");

endmodule

bind max_pool_window_argmax mpwa_checker u_mpwa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_type_i  (req_type_i),
  .done_o      (done_o),
  .max_value_o (max_value_o),
  .max_row_o   (max_row_o),
  .max_col_o   (max_col_o),
  .status_o    (status_o)
);

`default_nettype wire

// ===== verif/max_pool_window_argmax_checker.sv =====
// Checker for the max-pool window argmax block: mirrors its registers and pixel store,
// predicts each result word and compares it field by field. Depends on mpwa_pkg.
`timescale 1ns / 1ps

module max_pool_window_argmax_checker
  import mpwa_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       req_type_i,
  input  logic [CH_BITS-1:0]         channel_sel_i,
  input  logic [POS_BITS-1:0]        pos_row_i,
  input  logic [POS_BITS-1:0]        pos_col_i,
  input  logic signed [VALUE_BITS-1:0] pixel_value_i,
  // configuration channel
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i,
  // result channel
  input  logic                       done_i,
  input  logic signed [VALUE_BITS-1:0] max_value_i,
  input  logic [POS_BITS-1:0]        max_row_i,
  input  logic [POS_BITS-1:0]        max_col_i,
  input  logic                       status_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int MAX_W   = 32;
  localparam int MAX_H   = 32;
  localparam int MAX_CH  = 4;
  localparam int MAX_WIN = 8;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]          row;
    logic [POS_BITS-1:0]          col;
    logic                         status;
  } pool_word_t;

  // Mirror of the register file and the pixel store
  logic [5:0] width_q, height_q;
  logic [2:0] chans_q;
  logic [3:0] size_q, stride_q;
  logic signed [VALUE_BITS-1:0] pix_mem [0:MAX_CH*MAX_H*MAX_W-1];

  pool_word_t pooled_q[$];
  int         errors = 0;

  // Work out the result word of one request; a stored write also updates the mirror
  task automatic pool_predict(input logic rtype, input logic [CH_BITS-1:0] ch,
                              input logic [POS_BITS-1:0] pr, input logic [POS_BITS-1:0] pc,
                              input logic signed [VALUE_BITS-1:0] pix,
                              output pool_word_t res);
    int  w, h, nch, sz, st, outh, outw, ar, ac, half, r0, r1, c0, c1, v, best, br, bc;
    bit  have;
    res.value  = '0;
    res.row    = '0;
    res.col    = '0;
    res.status = STATUS_ERR;
    w   = (width_q > MAX_W) ? MAX_W : int'(width_q);
    h   = (height_q > MAX_H) ? MAX_H : int'(height_q);
    nch = (chans_q > MAX_CH) ? MAX_CH : int'(chans_q);
    sz  = (size_q > MAX_WIN) ? MAX_WIN : int'(size_q);
    st  = int'(stride_q);
    if (sz == 0) sz = 1;
    if (st == 0) st = 1;
    if (w == 0 || h == 0 || int'(ch) >= nch) return;

    if (rtype == REQ_WRITE) begin
      if (int'(pr) >= h || int'(pc) >= w) return;
      pix_mem[(int'(ch) * MAX_H + int'(pr)) * MAX_W + int'(pc)] = pix;
      res.status = STATUS_OK;
      return;
    end

    outh = (h - 1) / st + 1;
    outw = (w - 1) / st + 1;
    if (int'(pr) >= outh || int'(pc) >= outw) return;
    ar = int'(pr) * st;
    ac = int'(pc) * st;
    // odd windows centre on the anchor, even ones hang down and right of it
    if (sz % 2 == 1) begin
      half = (sz - 1) / 2;
      r0 = ar - half;
      r1 = ar + half;
      c0 = ac - half;
      c1 = ac + half;
    end else begin
      r0 = ar;
      r1 = ar + sz - 1;
      c0 = ac;
      c1 = ac + sz - 1;
    end
    if (r0 < 0) r0 = 0;
    if (c0 < 0) c0 = 0;
    if (r1 > h - 1) r1 = h - 1;
    if (c1 > w - 1) c1 = w - 1;

    // scan row-major; only a strictly greater pixel takes over
    have = 1'b0;
    best = 0;
    br   = 0;
    bc   = 0;
    for (int r = r0; r <= r1; r++) begin
      for (int x = c0; x <= c1; x++) begin
        v = int'(pix_mem[(int'(ch) * MAX_H + r) * MAX_W + x]);
        if (!have || v > best) begin
          have = 1'b1;
          best = v;
          br   = r;
          bc   = x;
        end
      end
    end
    res.value  = best[VALUE_BITS-1:0];
    res.row    = br[POS_BITS-1:0];
    res.col    = bc[POS_BITS-1:0];
    res.status = STATUS_OK;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Compare result words first, then take config and request words of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    pool_word_t got, want;
    if (!rst_ni) begin
      width_q  = 6'd32;
      height_q = 6'd32;
      chans_q  = 3'd1;
      size_q   = 4'd2;
      stride_q = 4'd2;
      pooled_q.delete();
    end else begin
      if (done_i) begin
        got = '{value: max_value_i, row: max_row_i, col: max_col_i, status: status_i};
        if (pooled_q.size() == 0) begin
          errors++;
          $display("%0t ns: result word with none expected, %s %0d row %0d col %0d status %0d",
                   $time, "actual value", got.value, got.row, got.col, got.status);
        end else begin
          want = pooled_q.pop_front();
          check_field("max_value", int'($signed(want.value)), int'($signed(got.value)));
          check_field("max_row", int'(want.row), int'(got.row));
          check_field("max_col", int'(want.col), int'(got.col));
          check_field("status", int'(want.status), int'(got.status));
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:   width_q  = cfg_data_i;
          CFG_FRAME_HEIGHT:  height_q = cfg_data_i;
          CFG_CHANNEL_COUNT: chans_q  = cfg_data_i[2:0];
          CFG_WINDOW_SIZE:   size_q   = cfg_data_i[3:0];
          CFG_WINDOW_STRIDE: stride_q = cfg_data_i[3:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        pool_predict(req_type_i, channel_sel_i, pos_row_i, pos_col_i, pixel_value_i, want);
        pooled_q.push_back(want);
      end
    end
    pending_o    = pooled_q.size();
    fail_count_o = errors;
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the max-pool window argmax testbench: clock, reset, request and config stimulus,
// and the verdict. Depends on mpwa_pkg, the block and max_pool_window_argmax_checker.
`timescale 1ns / 1ps

module testbench;
  import mpwa_pkg::*;

  localparam int MAX_W       = 32;
  localparam int MAX_H       = 32;
  localparam int MAX_CH      = 4;
  localparam int MAX_WIN     = 8;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 195;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         start = 1'b0;
  logic                         busy;
  logic                         req_type = REQ_WRITE;
  logic [CH_BITS-1:0]           channel_sel = '0;
  logic [POS_BITS-1:0]          pos_row = '0;
  logic [POS_BITS-1:0]          pos_col = '0;
  logic signed [VALUE_BITS-1:0] pixel_value = '0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_BITS-1:0]      cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
  logic                         done;
  logic signed [VALUE_BITS-1:0] max_value;
  logic [POS_BITS-1:0]          max_row;
  logic [POS_BITS-1:0]          max_col;
  logic                         status;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Stimulus-side view of the registers, kept to aim requests and avoid unwritten reads
  logic [5:0] raw_w, raw_h;
  logic [2:0] raw_nch;
  logic [3:0] raw_sz, raw_st;
  int         eff_w, eff_h, eff_nch, eff_sz, eff_st;
  bit         written_map [0:MAX_CH*MAX_H*MAX_W-1];
  int         burst_left = 0;
  int         phase_items = 0;

  max_pool_window_argmax u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type),
    .channel_sel_i (channel_sel),
    .pos_row_i     (pos_row),
    .pos_col_i     (pos_col),
    .pixel_value_i (pixel_value),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .done_o        (done),
    .max_value_o   (max_value),
    .max_row_o     (max_row),
    .max_col_o     (max_col),
    .status_o      (status)
  );

  max_pool_window_argmax_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .req_type_i    (req_type),
    .channel_sel_i (channel_sel),
    .pos_row_i     (pos_row),
    .pos_col_i     (pos_col),
    .pixel_value_i (pixel_value),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .done_i        (done),
    .max_value_i   (max_value),
    .max_row_i     (max_row),
    .max_col_i     (max_col),
    .status_i      (status),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic refresh_limits();
    eff_w   = (raw_w > MAX_W) ? MAX_W : int'(raw_w);
    eff_h   = (raw_h > MAX_H) ? MAX_H : int'(raw_h);
    eff_nch = (raw_nch > MAX_CH) ? MAX_CH : int'(raw_nch);
    eff_sz  = (raw_sz > MAX_WIN) ? MAX_WIN : int'(raw_sz);
    eff_st  = int'(raw_st);
    if (eff_sz == 0) eff_sz = 1;
    if (eff_st == 0) eff_st = 1;
  endtask

  function automatic logic [VALUE_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Clipped window of a query; returns 0 when the query reads nothing
  function automatic bit query_window(input int ch, input int pr, input int pc,
                                      output int r0, output int r1,
                                      output int c0, output int c1);
    int half;
    r0 = 0;
    r1 = -1;
    c0 = 0;
    c1 = -1;
    if (eff_w == 0 || eff_h == 0 || ch >= eff_nch) return 1'b0;
    if (pr >= (eff_h - 1) / eff_st + 1 || pc >= (eff_w - 1) / eff_st + 1) return 1'b0;
    if (eff_sz % 2 == 1) begin
      half = (eff_sz - 1) / 2;
      r0 = pr * eff_st - half;
      r1 = pr * eff_st + half;
      c0 = pc * eff_st - half;
      c1 = pc * eff_st + half;
    end else begin
      r0 = pr * eff_st;
      r1 = r0 + eff_sz - 1;
      c0 = pc * eff_st;
      c1 = c0 + eff_sz - 1;
    end
    if (r0 < 0) r0 = 0;
    if (c0 < 0) c0 = 0;
    if (r1 > eff_h - 1) r1 = eff_h - 1;
    if (c1 > eff_w - 1) c1 = eff_w - 1;
    return 1'b1;
  endfunction

  // Present one request word at the falling edge and hold it until accepted;
  // idle between bursts, sometimes draining all outstanding results first
  task automatic send_req(input logic rtype, input int ch, input int pr, input int pc,
                          input logic [VALUE_BITS-1:0] pix);
    if (burst_left == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 29) == 0) begin
        while (pending != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 9) < 7) repeat ($urandom_range(1, 4)) @(negedge clk_i);
      else repeat ($urandom_range(5, 70)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    start       <= 1'b1;
    req_type    <= rtype;
    channel_sel <= ch[CH_BITS-1:0];
    pos_row     <= pr[POS_BITS-1:0];
    pos_col     <= pc[POS_BITS-1:0];
    pixel_value <= pix;
    if (rtype == REQ_WRITE && ch < eff_nch && pr < eff_h && pc < eff_w)
      written_map[(ch * MAX_H + pr) * MAX_W + pc] = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    phase_items++;
  endtask

  // Write every pixel of the window that was never written, then query it
  task automatic issue_query(input int ch, input int pr, input int pc);
    int r0, r1, c0, c1;
    if (query_window(ch, pr, pc, r0, r1, c0, c1)) begin
      for (int r = r0; r <= r1; r++) begin
        for (int c = c0; c <= c1; c++) begin
          if (!written_map[(ch * MAX_H + r) * MAX_W + c])
            send_req(REQ_WRITE, ch, r, c, rand_pixel());
        end
      end
    end
    send_req(REQ_QUERY, ch, pr, pc, rand_pixel());
  endtask

  // Present one config word; valid stays high for the next one
  task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:   raw_w   = data;
      CFG_FRAME_HEIGHT:  raw_h   = data;
      CFG_CHANNEL_COUNT: raw_nch = data[2:0];
      CFG_WINDOW_SIZE:   raw_sz  = data[3:0];
      CFG_WINDOW_STRIDE: raw_st  = data[3:0];
      default: ;
    endcase
    refresh_limits();
  endtask

  task automatic configure_phase(input int w, input int h, input int n, input int s,
                                 input int t, input bit spare);
    if (spare) begin
      for (int i = int'(CFG_WINDOW_STRIDE) + 1; i < (1 << CFG_IDX_BITS); i++)
        program_reg(i[CFG_IDX_BITS-1:0], CFG_DATA_BITS'($urandom));
    end
    program_reg(CFG_FRAME_WIDTH, w[CFG_DATA_BITS-1:0]);
    program_reg(CFG_FRAME_HEIGHT, h[CFG_DATA_BITS-1:0]);
    program_reg(CFG_CHANNEL_COUNT, n[CFG_DATA_BITS-1:0]);
    program_reg(CFG_WINDOW_SIZE, s[CFG_DATA_BITS-1:0]);
    program_reg(CFG_WINDOW_STRIDE, t[CFG_DATA_BITS-1:0]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ch, pr, pc, kind;
    raw_w   = 6'd32;
    raw_h   = 6'd32;
    raw_nch = 3'd1;
    raw_sz  = 4'd2;
    raw_st  = 4'd2;
    refresh_limits();
    for (int i = 0; i < MAX_CH * MAX_H * MAX_W; i++) written_map[i] = 1'b0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // drop the request line and drain before touching registers
        start <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk_i);
        @(negedge clk_i);
        case (p)
          1:       configure_phase(8, 8, 4, 3, 1, 1'b0);
          2:       configure_phase(1, 1, 1, 1, 1, 1'b0);
          3:       configure_phase(5, 7, 2, 8, 3, 1'b0);
          4:       configure_phase(63, 63, 7, 15, 15, 1'b1);
          5:       configure_phase(0, 4, 2, 0, 0, 1'b0);
          6:       configure_phase(6, 3, 3, 0, 0, 1'b0);
          7:       configure_phase(32, 32, 1, 7, 8, 1'b0);
          8:       configure_phase(17, 0, 0, 5, 6, 1'b0);
          default: configure_phase(20, 11, 3, 6, 5, 1'b0);
        endcase
      end
      phase_items = 0;

      if (p == 0) begin
        // tie at the top-left window: the first extreme in scan order wins
        send_req(REQ_WRITE, 0, 0, 0, 16'h7FFF);
        send_req(REQ_WRITE, 0, 0, 1, 16'h8000);
        send_req(REQ_WRITE, 0, 1, 0, 16'h7FFF);
        send_req(REQ_WRITE, 0, 1, 1, 16'h0000);
        issue_query(0, 0, 0);
        // bottom-right window, all pixels equal and most negative
        for (int r = MAX_H - 2; r < MAX_H; r++) begin
          for (int c = MAX_W - 2; c < MAX_W; c++) send_req(REQ_WRITE, 0, r, c, 16'h8000);
        end
        issue_query(0, 15, 15);
        // output position and channel just out of range
        issue_query(0, 16, 0);
        issue_query(0, 0, 16);
        send_req(REQ_WRITE, 3, 31, 31, 16'h1234);
        send_req(REQ_WRITE, 1, 0, 0, 16'h4321);
        issue_query(2, 0, 0);
      end

      while (phase_items < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 10 || eff_w == 0 || eff_h == 0 || eff_nch == 0) begin
          // noise: any field value at all
          ch = $urandom_range(0, 3);
          pr = $urandom_range(0, 31);
          pc = $urandom_range(0, 31);
          if ($urandom_range(0, 1) == 1) issue_query(ch, pr, pc);
          else send_req(REQ_WRITE, ch, pr, pc, rand_pixel());
        end else if (kind < 55) begin
          ch = $urandom_range(0, eff_nch - 1);
          if ($urandom_range(0, 9) == 0) begin
            pr = $urandom_range(0, 31);
            pc = $urandom_range(0, 31);
          end else begin
            pr = $urandom_range(0, (eff_h - 1) / eff_st);
            pc = $urandom_range(0, (eff_w - 1) / eff_st);
          end
          issue_query(ch, pr, pc);
        end else begin
          ch = $urandom_range(0, eff_nch - 1);
          pr = $urandom_range(0, eff_h - 1);
          pc = $urandom_range(0, eff_w - 1);
          send_req(REQ_WRITE, ch, pr, pc, rand_pixel());
        end
      end
    end

    // drain, then allow one full query scan of settling
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
